// ===== sv/phr_pkg.sv =====
// phr_pkg: shared types and constants of the publish header parser
// depends on nothing; used by phr_in_reg, phr_parser, phr_out_reg and the top level
package phr_pkg;

  // length bytes allowed before the field counts as malformed, never above four
  localparam int MaxLengthBytes = 4;
  localparam int LenLimit = (MaxLengthBytes < 4) ? MaxLengthBytes : 4;

  localparam int ByteW = 8;
  localparam int LenW = 28;
  localparam int HalfW = 16;
  localparam int TdataW = 104;
  localparam int TuserW = 4;

  typedef enum logic [2:0] {
    PH_FIXED = 3'd0,
    PH_LEN   = 3'd1,
    PH_TLH   = 3'd2,
    PH_TLL   = 3'd3,
    PH_TOPIC = 3'd4,
    PH_IDH   = 3'd5,
    PH_IDL   = 3'd6,
    PH_PAY   = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    K_FIXED = 3'd0,
    K_LEN   = 3'd1,
    K_TLEN  = 3'd2,
    K_TOPIC = 3'd3,
    K_ID    = 3'd4,
    K_PAY   = 3'd5,
    K_BAD   = 3'd6
  } kind_e;

  typedef struct packed {
    logic [LenW-1:0]  payload_length;
    logic [HalfW-1:0] packet_id;
    logic [HalfW-1:0] topic_length;
    logic [LenW-1:0]  remaining_length;
    logic             retain_flag;
    logic [1:0]       qos_level;
    logic             dup_flag;
    logic [3:0]       packet_type;
    logic [ByteW-1:0] byte_out;
    logic             packet_end;
    logic             header_done;
    kind_e            byte_kind;
  } phr_result_t;

endpackage

// ===== sv/phr_in_reg.sv =====
// phr_in_reg: input register of the publish header parser, one byte deep
// depends on phr_pkg
module phr_in_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_valid_i,
  output logic                     s_ready_o,
  input  logic [phr_pkg::ByteW-1:0] s_byte_i,
  input  logic                     advance_i,
  output logic                     valid_o,
  output logic [phr_pkg::ByteW-1:0] byte_o
);
  import phr_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  // a byte may enter while the held one moves on in the same cycle
  assign s_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_valid_i && s_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      byte_q <= s_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== sv/phr_parser.sv =====
// phr_parser: parse state and per-byte classification and field decode
// depends on phr_pkg; state moves only when advance_i is high
module phr_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [phr_pkg::ByteW-1:0] byte_i,
  output phr_pkg::phr_result_t      result_o
);
  import phr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [7:0]       hdr_q, hdr_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [HalfW-1:0] tlen_q, tlen_d;
  logic [HalfW-1:0] tleft_q, tleft_d;
  logic [HalfW-1:0] id_q, id_d;

  phase_e           nxt;
  kind_e            kind;
  logic             hdone;
  logic             pend;
  logic [LenW-1:0]  group;
  logic             qos_nz;
  logic [17:0]      var_len;
  logic [LenW-1:0]  plen;

  assign qos_nz = (hdr_q[2:1] != 2'd0);

  // current length group placed at its 7-bit offset
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    group = LenW'(byte_i[6:0]);
      2'd1:    group = LenW'(byte_i[6:0]) << 7;
      2'd2:    group = LenW'(byte_i[6:0]) << 14;
      default: group = LenW'(byte_i[6:0]) << 21;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    tlen_d  = tlen_q;
    tleft_d = tleft_q;
    id_d    = id_q;
    nxt     = phase_q;
    kind    = K_BAD;
    hdone   = 1'b0;
    pend    = 1'b0;
    unique case (phase_q)
      PH_FIXED: begin
        hdr_d   = byte_i;
        len_d   = '0;
        cnt_d   = '0;
        left_d  = '0;
        tlen_d  = '0;
        tleft_d = '0;
        id_d    = '0;
        kind    = K_FIXED;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        if (cnt_q >= 3'(LenLimit)) begin
          kind    = K_BAD;
          phase_d = PH_FIXED;
        end else begin
          len_d = len_q | group;
          cnt_d = cnt_q + 3'd1;
          kind  = K_LEN;
          if (!byte_i[7]) begin
            left_d = len_d;
            if (len_d == '0) begin
              // zero remaining length cannot hold a publish header
              kind    = K_BAD;
              pend    = 1'b1;
              phase_d = PH_FIXED;
            end else begin
              phase_d = PH_TLH;
            end
          end
        end
      end
      PH_PAY: begin
        kind = K_PAY;
        if (left_q != '0) begin
          left_d = left_q - LenW'(1);
        end
        if (left_d == '0) begin
          pend    = 1'b1;
          phase_d = PH_FIXED;
        end
      end
      default: begin
        unique case (phase_q)
          PH_TLH: begin
            tlen_d = {byte_i, 8'h00};
            kind   = K_TLEN;
            nxt    = PH_TLL;
          end
          PH_TLL: begin
            tlen_d  = tlen_q | {8'h00, byte_i};
            tleft_d = tlen_d;
            kind    = K_TLEN;
            nxt     = (tleft_d != '0) ? PH_TOPIC : (qos_nz ? PH_IDH : PH_PAY);
          end
          PH_TOPIC: begin
            kind = K_TOPIC;
            if (tleft_q != '0) begin
              tleft_d = tleft_q - HalfW'(1);
            end
            nxt = (tleft_d != '0) ? PH_TOPIC : (qos_nz ? PH_IDH : PH_PAY);
          end
          PH_IDH: begin
            id_d = {byte_i, 8'h00};
            kind = K_ID;
            nxt  = PH_IDL;
          end
          default: begin
            id_d = id_q | {8'h00, byte_i};
            kind = K_ID;
            nxt  = PH_PAY;
          end
        endcase
        if (left_q != '0) begin
          left_d = left_q - LenW'(1);
        end
        hdone = (nxt == PH_PAY);
        if (left_d == '0) begin
          pend = 1'b1;
          // packet ran out before the variable header was complete
          if (nxt != PH_PAY) begin
            kind  = K_BAD;
            hdone = 1'b0;
          end
          phase_d = PH_FIXED;
        end else begin
          phase_d = nxt;
        end
      end
    endcase
  end

  // payload length = remaining length minus the variable header, floored at zero
  assign var_len = 18'd2 + 18'(tlen_d) + (qos_nz ? 18'd2 : 18'd0);

  always_comb begin
    plen = '0;
    if (hdone || kind == K_PAY) begin
      if (len_q >= LenW'(var_len)) begin
        plen = len_q - LenW'(var_len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIXED;
      hdr_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      tlen_q  <= '0;
      tleft_q <= '0;
      id_q    <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      tlen_q  <= tlen_d;
      tleft_q <= tleft_d;
      id_q    <= id_d;
    end
  end

  always_comb begin
    result_o.byte_kind        = kind;
    result_o.header_done      = hdone;
    result_o.packet_end       = pend;
    result_o.byte_out         = byte_i;
    result_o.packet_type      = hdr_d[7:4];
    result_o.dup_flag         = hdr_d[3];
    result_o.qos_level        = hdr_d[2:1];
    result_o.retain_flag      = hdr_d[0];
    result_o.remaining_length = len_d;
    result_o.topic_length     = tlen_d;
    result_o.packet_id        = id_d;
    result_o.payload_length   = plen;
  end

endmodule

// ===== sv/phr_out_reg.sv =====
// phr_out_reg: result register of the publish header parser
// depends on phr_pkg; holds one result until the master side takes it
module phr_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 advance_o,
  input  phr_pkg::phr_result_t result_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output phr_pkg::phr_result_t result_o
);
  import phr_pkg::*;

  logic        valid_q;
  phr_result_t result_q;

  // load when empty or when the held result is taken in this cycle
  assign advance_o = valid_i && (!valid_q || m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign result_o  = result_q;

endmodule

// ===== sv/publish_header_parser.sv =====
// publish_header_parser: byte-stream parser for publish packet headers
// depends on phr_pkg, phr_in_reg, phr_parser and phr_out_reg
//
// channel  | dir | tdata                               | tuser            | tlast
// s_axis   | in  | data_byte                           | -                | -
// m_axis   | out | byte_out .. payload_length (104 b)  | byte_kind, hdone | packet_end
//
// one byte per cycle sustained while the master side does not stall; a byte's result reaches
// m_axis through the input register, then the result register, and the parse state is
// updated once per byte
// reset clears the parse state to expect a fixed header and empties both registers
// a stalled master side holds its result; one more byte is taken into the input
// register, after which s_axis_tready_o drops until the result moves on
module publish_header_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [phr_pkg::ByteW-1:0]   s_axis_tdata_i,   // [7:0] data_byte
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [7:0] byte_out, [11:8] packet_type, [12] dup_flag, [14:13] qos_level,
  // [15] retain_flag, [43:16] remaining_length, [59:44] topic_length,
  // [75:60] packet_id, [103:76] payload_length
  output logic [phr_pkg::TdataW-1:0]  m_axis_tdata_o,
  output logic [phr_pkg::TuserW-1:0]  m_axis_tuser_o,   // [2:0] byte_kind, [3] header_done
  output logic                        m_axis_tlast_o    // packet_end
);
  import phr_pkg::*;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             advance;
  phr_result_t      result;
  phr_result_t      out_result;

  phr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_byte_i  (s_axis_tdata_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  phr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte),
    .result_o  (result)
  );

  phr_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid),
    .advance_o (advance),
    .result_i  (result),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .result_o  (out_result)
  );

  assign m_axis_tdata_o = {out_result.payload_length, out_result.packet_id,
                           out_result.topic_length, out_result.remaining_length,
                           out_result.retain_flag, out_result.qos_level,
                           out_result.dup_flag, out_result.packet_type,
                           out_result.byte_out};
  assign m_axis_tuser_o = {out_result.header_done, out_result.byte_kind};
  assign m_axis_tlast_o = out_result.packet_end;

  // a fixed header byte never ends a packet or a header
  a_fixed_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_result.byte_kind == K_FIXED
      |-> !out_result.packet_end && !out_result.header_done)
    else $error("fixed header byte flagged as end");

  // header completion only on a variable header byte
  a_hdone_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_result.header_done
      |-> out_result.byte_kind == K_TLEN || out_result.byte_kind == K_TOPIC ||
          out_result.byte_kind == K_ID)
    else $error("header_done on wrong byte kind");

  // payload length is reported only once the header is done
  a_plen_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_result.payload_length != '0
      |-> out_result.header_done || out_result.byte_kind == K_PAY)
    else $error("payload length outside payload");

  // a byte waiting in the input register is not dropped while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("input byte lost during stall");

endmodule
